@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RFPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define RFPC_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ rtl/rfpc_pkg.sv @@
// Shared types and constants of the radio front panel controller.
package rfpc_pkg;

    localparam int unsigned FREQ_MIN  = 8750;
    localparam int unsigned FREQ_MAX  = 10800;
    localparam int unsigned FREQ_SPAN = 2050;
    localparam int unsigned VOL_MAX   = 15;

    // Reciprocal of ten in Q0.16, exact for the rounded frequency range.
    localparam logic [12:0] RECIP_TEN = 13'd6554;

    // Infrared command codes.
    localparam logic [7:0] CMD_REC_START = 8'h0C;
    localparam logic [7:0] CMD_REC_STOP  = 8'h0B;
    localparam logic [7:0] CMD_SEEK_UP   = 8'h20;
    localparam logic [7:0] CMD_SEEK_DOWN = 8'h21;
    localparam logic [7:0] CMD_VOL_UP    = 8'h10;
    localparam logic [7:0] CMD_VOL_DOWN  = 8'h11;
    localparam logic [7:0] CMD_MUTE      = 8'h0D;

    // Action codes on the result.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_FIRST = 2'd1;
    localparam logic [1:0] ACT_SECOND = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_FREQ_LOW  = 3'd0;
    localparam logic [2:0] REG_FREQ_HIGH = 3'd1;
    localparam logic [2:0] REG_VOL_LOW   = 3'd2;
    localparam logic [2:0] REG_VOL_HIGH  = 3'd3;
    localparam logic [2:0] REG_FREQ_ALPHA = 3'd4;
    localparam logic [2:0] REG_VOL_ALPHA = 3'd5;

    // Classified actions of one tick, passed from front to back.
    typedef struct packed {
        logic [1:0] mutes;
        logic [1:0] seek;
        logic [1:0] vstep;
        logic [1:0] rec;
        logic       unknown;
        logic       fovr;
        logic       vovr;
    } action_t;

endpackage

@@ rtl/rfpc_queue.sv @@
// Two-entry queue between the front and back parts.
module rfpc_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/rfpc_front.sv @@
// Front part: takes a tick, smooths the pots, classifies buttons and IR.
module rfpc_front #(
    parameter int ADC_BITS = 10,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ADC_BITS-1:0]        freq_sample,
    input  logic [ADC_BITS-1:0]        vol_sample,
    input  logic                       mute_pressed,
    input  logic                       start_pressed,
    input  logic                       stop_pressed,
    input  logic                       ir_valid,
    input  logic [7:0]                 ir_command,
    input  logic                       ir_repeat,
    input  logic [ALPHA_FRAC_BITS-1:0] freq_alpha,
    input  logic [ALPHA_FRAC_BITS-1:0] vol_alpha,
    input  logic                       q_full,
    output logic                       push,
    output logic [ADC_BITS-1:0]        push_freq_rd,
    output logic [ADC_BITS-1:0]        push_vol_rd,
    output rfpc_pkg::action_t          push_act
);

    localparam int F     = ALPHA_FRAC_BITS;
    localparam int AVG_W = ADC_BITS + F;

    logic                busy_reg;
    logic [ADC_BITS-1:0] fs_reg, vs_reg;
    logic                mute_reg, start_reg, stop_reg, irv_reg, irr_reg;
    logic [7:0]          cmd_reg;

    logic [AVG_W-1:0]    favg_reg, vavg_reg, favg_next, vavg_next;
    logic                seeded_reg;
    logic [ADC_BITS-1:0] lastf_reg, lastv_reg;
    logic                fovr_reg, vovr_reg, rep_reg;
    logic                fovr_next, vovr_next, rep_next;

    logic [F:0]            f_w1, v_w1;
    logic [F+ADC_BITS-1:0] f_p0, v_p0;
    logic [2*F+ADC_BITS:0] f_p1, v_p1;
    logic [AVG_W+1:0]      f_sum, v_sum;
    logic [ADC_BITS-1:0]   f_rd, v_rd;
    logic                  ir_take;
    rfpc_pkg::action_t     act;

    assign in_ready = !busy_reg;
    assign push     = busy_reg && !q_full;

    // Weighted sum: alpha * sample plus (1 - alpha) * old average, truncated; the first beat seeds the average.
    always_comb
    begin
        f_w1 = {1'b1, {F{1'b0}}} - {1'b0, freq_alpha};
        v_w1 = {1'b1, {F{1'b0}}} - {1'b0, vol_alpha};
        f_p0 = (F+ADC_BITS)'(freq_alpha) * (F+ADC_BITS)'(fs_reg);
        v_p0 = (F+ADC_BITS)'(vol_alpha) * (F+ADC_BITS)'(vs_reg);
        f_p1 = (2*F+ADC_BITS+1)'(f_w1) * (2*F+ADC_BITS+1)'(favg_reg);
        v_p1 = (2*F+ADC_BITS+1)'(v_w1) * (2*F+ADC_BITS+1)'(vavg_reg);
        f_sum = (AVG_W+2)'(f_p0) + (AVG_W+2)'(f_p1 >> F);
        v_sum = (AVG_W+2)'(v_p0) + (AVG_W+2)'(v_p1 >> F);
        if (seeded_reg)
        begin
            favg_next = f_sum[AVG_W-1:0];
            vavg_next = v_sum[AVG_W-1:0];
        end
        else
        begin
            favg_next = {fs_reg, {F{1'b0}}};
            vavg_next = {vs_reg, {F{1'b0}}};
        end
        f_rd = favg_next[AVG_W-1:F];
        v_rd = vavg_next[AVG_W-1:F];
    end

    always_comb
    begin
        ir_take   = irv_reg && (rep_reg || !irr_reg);
        act       = '0;
        fovr_next = (f_rd != lastf_reg) ? 1'b0 : fovr_reg;
        vovr_next = (v_rd != lastv_reg) ? 1'b0 : vovr_reg;
        rep_next  = ir_take ? 1'b0 : rep_reg;
        act.mutes = {1'b0, mute_reg};
        if (ir_take)
        begin
            unique case (cmd_reg)
                rfpc_pkg::CMD_REC_START: act.rec = rfpc_pkg::ACT_FIRST;
                rfpc_pkg::CMD_REC_STOP:  act.rec = rfpc_pkg::ACT_SECOND;
                rfpc_pkg::CMD_SEEK_UP:
                begin
                    fovr_next = 1'b1;
                    act.seek  = rfpc_pkg::ACT_FIRST;
                    rep_next  = 1'b1;
                end
                rfpc_pkg::CMD_SEEK_DOWN:
                begin
                    fovr_next = 1'b1;
                    act.seek  = rfpc_pkg::ACT_SECOND;
                    rep_next  = 1'b1;
                end
                rfpc_pkg::CMD_VOL_UP:
                begin
                    vovr_next = 1'b1;
                    act.vstep = rfpc_pkg::ACT_FIRST;
                    rep_next  = 1'b1;
                end
                rfpc_pkg::CMD_VOL_DOWN:
                begin
                    vovr_next = 1'b1;
                    act.vstep = rfpc_pkg::ACT_SECOND;
                    rep_next  = 1'b1;
                end
                rfpc_pkg::CMD_MUTE: act.mutes = act.mutes + 2'd1;
                default: act.unknown = 1'b1;
            endcase
        end
        if (start_reg)
        begin
            act.rec = rfpc_pkg::ACT_FIRST;
        end
        if (stop_reg)
        begin
            act.rec = rfpc_pkg::ACT_SECOND;
        end
        act.fovr = fovr_next;
        act.vovr = vovr_next;
    end

    assign push_freq_rd = f_rd;
    assign push_vol_rd  = v_rd;
    assign push_act     = act;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fs_reg    <= freq_sample;
            vs_reg    <= vol_sample;
            mute_reg  <= mute_pressed;
            start_reg <= start_pressed;
            stop_reg  <= stop_pressed;
            irv_reg   <= ir_valid;
            cmd_reg   <= ir_command;
            irr_reg   <= ir_repeat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            favg_reg   <= '0;
            vavg_reg   <= '0;
            seeded_reg <= 1'b0;
            lastf_reg  <= '0;
            lastv_reg  <= '0;
            fovr_reg   <= 1'b0;
            vovr_reg   <= 1'b0;
            rep_reg    <= 1'b0;
        end
        else if (push)
        begin
            busy_reg   <= 1'b0;
            favg_reg   <= favg_next;
            vavg_reg   <= vavg_next;
            seeded_reg <= 1'b1;
            lastf_reg  <= f_rd;
            lastv_reg  <= v_rd;
            fovr_reg   <= fovr_next;
            vovr_reg   <= vovr_next;
            rep_reg    <= rep_next;
        end
        else if (in_valid && in_ready)
        begin
            busy_reg <= 1'b1;
        end
    end

endmodule

@@ rtl/rfpc_back.sv @@
// Back part: maps the readings through a shared serial divider and holds the result.
module rfpc_back #(
    parameter int ADC_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    output logic                pop,
    input  logic [ADC_BITS-1:0] q_freq_rd,
    input  logic [ADC_BITS-1:0] q_vol_rd,
    input  rfpc_pkg::action_t   q_act,
    input  logic [ADC_BITS-1:0] freq_pot_low,
    input  logic [ADC_BITS-1:0] freq_pot_high,
    input  logic [ADC_BITS-1:0] vol_pot_low,
    input  logic [ADC_BITS-1:0] vol_pot_high,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [13:0]         tuned_freq,
    output logic [3:0]          volume_level,
    output logic [1:0]          mute_toggles,
    output logic [1:0]          seek_request,
    output logic [1:0]          remote_vol_step,
    output logic [1:0]          rec_action,
    output logic                freq_overridden,
    output logic                vol_overridden,
    output logic                ir_unknown
);

    localparam int NUM_W = ADC_BITS + 12;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic signed [NUM_W:0] K_FREQ = (NUM_W+1)'(rfpc_pkg::FREQ_SPAN);
    localparam logic signed [NUM_W:0] K_VOL  = (NUM_W+1)'(rfpc_pkg::VOL_MAX);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FSET  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_FPOST = 3'd3;
    localparam logic [2:0] S_FRND  = 3'd4;
    localparam logic [2:0] S_VSET  = 3'd5;
    localparam logic [2:0] S_VPOST = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]          state_reg;
    logic                chan_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ADC_BITS-1:0] frd_reg, vrd_reg;
    rfpc_pkg::action_t   act_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [ADC_BITS:0]   rem_reg;
    logic [ADC_BITS-1:0] den_reg;
    logic                neg_reg, zero_reg;
    logic [13:0]         fclamp_reg, fround_reg;
    logic [3:0]          vol_reg;
    logic                ovalid_reg;
    logic [13:0]         o_freq_reg;
    logic [3:0]          o_vol_reg;
    rfpc_pkg::action_t   o_act_reg;

    // Setup of one map: numerator and divisor magnitudes.
    logic [ADC_BITS-1:0]     s_rd, s_lo, s_hi;
    logic signed [ADC_BITS:0] s_diff, s_span;
    logic signed [NUM_W:0]   s_num, s_k, s_num_abs;
    logic signed [ADC_BITS:0] s_span_abs;
    // Divider step and signed quotient.
    logic [ADC_BITS:0]       d_sh;
    logic                    d_ge;
    logic signed [NUM_W:0]   qs;
    // Rounding to tens.
    logic [13:0]             r_in;
    logic [26:0]             r_prod;
    logic [10:0]             r_q;

    always_comb
    begin
        if (state_reg == S_FSET)
        begin
            s_rd = frd_reg;
            s_lo = freq_pot_low;
            s_hi = freq_pot_high;
            s_k  = K_FREQ;
        end
        else
        begin
            s_rd = vrd_reg;
            s_lo = vol_pot_low;
            s_hi = vol_pot_high;
            s_k  = K_VOL;
        end
        s_diff     = $signed({1'b0, s_rd}) - $signed({1'b0, s_lo});
        s_span     = $signed({1'b0, s_hi}) - $signed({1'b0, s_lo});
        s_num      = (NUM_W+1)'(s_diff) * s_k;
        s_num_abs  = s_num[NUM_W] ? -s_num : s_num;
        s_span_abs = s_span[ADC_BITS] ? -s_span : s_span;

        d_sh = {rem_reg[ADC_BITS-1:0], quo_reg[NUM_W-1]};
        d_ge = d_sh >= {1'b0, den_reg};

        if (zero_reg)
        begin
            qs = '0;
        end
        else if (neg_reg)
        begin
            qs = -$signed({1'b0, quo_reg});
        end
        else
        begin
            qs = $signed({1'b0, quo_reg});
        end

        r_in   = fclamp_reg + 14'd5;
        r_prod = 27'(r_in) * 27'(rfpc_pkg::RECIP_TEN);
        r_q    = r_prod[26:16];
    end

    assign pop = (state_reg == S_IDLE) && !q_empty;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                frd_reg <= q_freq_rd;
                vrd_reg <= q_vol_rd;
                act_reg <= q_act;
            end
            S_FSET, S_VSET:
            begin
                quo_reg  <= s_num_abs[NUM_W-1:0];
                den_reg  <= s_span_abs[ADC_BITS-1:0];
                rem_reg  <= '0;
                neg_reg  <= s_num[NUM_W] ^ s_span[ADC_BITS];
                zero_reg <= (s_span == '0);
            end
            S_DIV:
            begin
                if (d_ge)
                begin
                    rem_reg <= d_sh - {1'b0, den_reg};
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= d_sh;
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
            end
            S_FPOST:
            begin
                if (qs < 0)
                begin
                    fclamp_reg <= 14'(rfpc_pkg::FREQ_MIN);
                end
                else if (qs > $signed((NUM_W+1)'(rfpc_pkg::FREQ_SPAN)))
                begin
                    fclamp_reg <= 14'(rfpc_pkg::FREQ_MAX);
                end
                else
                begin
                    fclamp_reg <= 14'(qs) + 14'(rfpc_pkg::FREQ_MIN);
                end
            end
            S_FRND:
            begin
                fround_reg <= {r_q, 3'b000} + {2'b00, r_q, 1'b0};
            end
            S_VPOST:
            begin
                if (qs < 0)
                begin
                    vol_reg <= '0;
                end
                else if (qs > $signed((NUM_W+1)'(rfpc_pkg::VOL_MAX)))
                begin
                    vol_reg <= 4'(rfpc_pkg::VOL_MAX);
                end
                else
                begin
                    vol_reg <= qs[3:0];
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    o_freq_reg <= fround_reg;
                    o_vol_reg  <= vol_reg;
                    o_act_reg  <= act_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            chan_reg   <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_FSET;
                    end
                end
                S_FSET:
                begin
                    chan_reg  <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_VSET:
                begin
                    chan_reg  <= 1'b1;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        state_reg <= chan_reg ? S_VPOST : S_FPOST;
                    end
                end
                S_FPOST: state_reg <= S_FRND;
                S_FRND:  state_reg <= S_VSET;
                S_VPOST: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = ovalid_reg;
    assign tuned_freq      = o_freq_reg;
    assign volume_level    = o_vol_reg;
    assign mute_toggles    = o_act_reg.mutes;
    assign seek_request    = o_act_reg.seek;
    assign remote_vol_step = o_act_reg.vstep;
    assign rec_action      = o_act_reg.rec;
    assign freq_overridden = o_act_reg.fovr;
    assign vol_overridden  = o_act_reg.vovr;
    assign ir_unknown      = o_act_reg.unknown;

endmodule

@@ rtl/radio_front_panel_controller_unit.sv @@
// Top level of the radio front panel controller.
// Each input beat is registered by the front part, pushed into the two-entry queue and
// then taken by the back part; the front part takes a new beat once it has pushed the last.
// The back part takes a new beat only after it has issued the last result, as it runs
// the shared bit-serial divider for the frequency map and then for the volume map.
// Reset (rst_n, asynchronous, active low) clears averages, flags, the queue and
// the result valid flag and loads the calibration defaults; no clearing pass.
module radio_front_panel_controller_unit #(
    parameter int ADC_BITS = 10,
    parameter int ALPHA_FRAC_BITS = 16,
    localparam int CFG_W = (ADC_BITS > ALPHA_FRAC_BITS) ? ADC_BITS : ALPHA_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write port.
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // Input channel.
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADC_BITS-1:0] freq_sample,
    input  logic [ADC_BITS-1:0] vol_sample,
    input  logic                mute_pressed,
    input  logic                start_pressed,
    input  logic                stop_pressed,
    input  logic                ir_valid,
    input  logic [7:0]          ir_command,
    input  logic                ir_repeat,
    // Result channel.
    output logic                out_valid,
    input  logic                out_ready,
    output logic [13:0]         tuned_freq,
    output logic [3:0]          volume_level,
    output logic [1:0]          mute_toggles,
    output logic [1:0]          seek_request,
    output logic [1:0]          remote_vol_step,
    output logic [1:0]          rec_action,
    output logic                freq_overridden,
    output logic                vol_overridden,
    output logic                ir_unknown
);

    localparam int F   = ALPHA_FRAC_BITS;
    localparam int Q_W = 2 * ADC_BITS + $bits(rfpc_pkg::action_t);

    // Calibration and smoothing registers.
    logic [ADC_BITS-1:0] freq_low_reg, freq_high_reg, vol_low_reg, vol_high_reg;
    logic [F-1:0]        freq_alpha_reg, vol_alpha_reg;

    // Front to queue, queue to back.
    logic                push, pop, q_full, q_empty;
    logic [ADC_BITS-1:0] push_freq_rd, push_vol_rd;
    rfpc_pkg::action_t   push_act;
    logic [Q_W-1:0]      q_out;

    // Registers must be written by the user only while the block is idle (the block
    // does not enforce it), so the datapath can read them without any shadowing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_low_reg   <= '0;
            freq_high_reg  <= '1;
            vol_low_reg    <= '0;
            vol_high_reg   <= '1;
            freq_alpha_reg <= F'(3277);
            vol_alpha_reg  <= F'(32768);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rfpc_pkg::REG_FREQ_LOW:   freq_low_reg   <= cfg_wdata[ADC_BITS-1:0];
                rfpc_pkg::REG_FREQ_HIGH:  freq_high_reg  <= cfg_wdata[ADC_BITS-1:0];
                rfpc_pkg::REG_VOL_LOW:    vol_low_reg    <= cfg_wdata[ADC_BITS-1:0];
                rfpc_pkg::REG_VOL_HIGH:   vol_high_reg   <= cfg_wdata[ADC_BITS-1:0];
                rfpc_pkg::REG_FREQ_ALPHA: freq_alpha_reg <= cfg_wdata[F-1:0];
                rfpc_pkg::REG_VOL_ALPHA:  vol_alpha_reg  <= cfg_wdata[F-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The front part smooths and classifies one beat and holds it until the
    // queue has room.
    rfpc_front #(
        .ADC_BITS       (ADC_BITS),
        .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .freq_sample  (freq_sample),
        .vol_sample   (vol_sample),
        .mute_pressed (mute_pressed),
        .start_pressed(start_pressed),
        .stop_pressed (stop_pressed),
        .ir_valid     (ir_valid),
        .ir_command   (ir_command),
        .ir_repeat    (ir_repeat),
        .freq_alpha   (freq_alpha_reg),
        .vol_alpha    (vol_alpha_reg),
        .q_full       (q_full),
        .push         (push),
        .push_freq_rd (push_freq_rd),
        .push_vol_rd  (push_vol_rd),
        .push_act     (push_act)
    );

    rfpc_queue #(
        .W(Q_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data({push_freq_rd, push_vol_rd, push_act}),
        .full     (q_full),
        .pop      (pop),
        .pop_data (q_out),
        .empty    (q_empty)
    );

    // The back part maps readings to frequency and volume and owns the
    // result register, which decouples it from the downstream ready.
    rfpc_back #(
        .ADC_BITS(ADC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .pop            (pop),
        .q_freq_rd      (q_out[Q_W-1 -: ADC_BITS]),
        .q_vol_rd       (q_out[Q_W-ADC_BITS-1 -: ADC_BITS]),
        .q_act          (q_out[$bits(rfpc_pkg::action_t)-1:0]),
        .freq_pot_low   (freq_low_reg),
        .freq_pot_high  (freq_high_reg),
        .vol_pot_low    (vol_low_reg),
        .vol_pot_high   (vol_high_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tuned_freq     (tuned_freq),
        .volume_level   (volume_level),
        .mute_toggles   (mute_toggles),
        .seek_request   (seek_request),
        .remote_vol_step(remote_vol_step),
        .rec_action     (rec_action),
        .freq_overridden(freq_overridden),
        .vol_overridden (vol_overridden),
        .ir_unknown     (ir_unknown)
    );

endmodule

@@ rtl/rfpc_checker.sv @@
// Port-level checks of the radio front panel controller and their bind.
`include "assert_macros.svh"

module rfpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [13:0] tuned_freq,
    input logic [1:0]  seek_request,
    input logic [1:0]  remote_vol_step,
    input logic [1:0]  rec_action,
    input logic        ir_unknown
);

    `RFPC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result beat dropped")
    `RFPC_ASSERT(a_freq_hold, clk, rst_n, out_valid && !out_ready |=> $stable(tuned_freq), "stalled frequency changed")
    `RFPC_NEVER(a_freq_range, clk, rst_n, out_valid && (tuned_freq < 14'd8750 || tuned_freq > 14'd10800), "frequency out of band")
    `RFPC_NEVER(a_one_cmd, clk, rst_n, out_valid && seek_request != 2'd0 && (remote_vol_step != 2'd0 || ir_unknown), "two IR actions in one beat")
    `RFPC_NEVER(a_codes, clk, rst_n, out_valid && (rec_action == 2'd3 || seek_request == 2'd3 || remote_vol_step == 2'd3), "invalid action code")

endmodule

bind radio_front_panel_controller_unit rfpc_checker u_rfpc_checker (.*);
